// File: src/text_console_writer_top_macros.svh
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tcw_pkg.sv
// Types, geometry and character codes of the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS + 1);
  localparam int CIDX_W  = $clog2(COLUMNS);
  localparam int ADDR_W  = $clog2(ROWS * COLUMNS);

  localparam int TAB_STEP = 4;
  localparam int TCNT_W   = $clog2(TAB_STEP + 1);

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int READ_ROW_W  = 5;
  localparam int READ_COL_W  = 7;
  localparam int CUR_ROW_W   = 5;
  localparam int CUR_COL_W   = 7;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef struct packed {
    logic                  opcode;
    logic [CHAR_W-1:0]     char_code;
    logic [READ_ROW_W-1:0] read_row;
    logic [READ_COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_word;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
  } out_item_t;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic exec;
    logic sweep;
    logic tab;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_scroll;
    logic need_wrap;
    logic need_tab;
    logic sweep_last;
    logic tab_last;
    logic item_lf;
  } dp_status_t;

endpackage

// File: src/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
`include "text_console_writer_top_macros.svh"

module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_TAB    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_scroll) begin
          state_nxt = ST_SCROLL;
        end else if (status.need_tab) begin
          state_nxt = ST_TAB;
        end else if (status.need_wrap) begin
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = status.item_lf ? ST_FINISH : ST_EXEC;
        end
      end
      ST_TAB: begin
        cmd.tab = 1'b1;
        if (status.tab_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TCW_ASSERT_NXT(a_accept_starts_exec, clk, rst_n, in_valid && !in_stall, state_r == ST_EXEC, "accepted item did not start execution")
  `TCW_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, state_r == ST_CLEAR, in_stall && !cmd.load, "input taken during clearing pass")

endmodule

// File: src/tcw_datapath.sv
// Cursor, row bookkeeping, screen store and result register of the console writer.
`include "text_console_writer_top_macros.svh"

module tcw_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcw_pkg::ctrl_cmd_t                cmd,
  output tcw_pkg::dp_status_t               status,
  input  tcw_pkg::in_item_t                 in_data,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]        cfg_wdata,
  output tcw_pkg::out_item_t                out_data
);

  localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] COL_FULL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::COL_W-1:0] COL_LAST = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

  function automatic logic [tcw_pkg::ADDR_W-1:0] cell_addr(
    input logic [tcw_pkg::ROW_W-1:0]  p,
    input logic [tcw_pkg::CIDX_W-1:0] c
  );
    return tcw_pkg::ADDR_W'(p) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(c);
  endfunction

  // Cursor in logical rows, its physical row in the store, and the ring base.
  logic [tcw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcw_pkg::ROW_W-1:0]  phys_r, phys_nxt;
  logic [tcw_pkg::ROW_W-1:0]  base_r, base_nxt;
  logic [tcw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcw_pkg::COL_W-1:0]  row_end_r [tcw_pkg::ROWS];
  logic                       row_end_we;
  logic [tcw_pkg::ROW_W-1:0]  row_end_idx;
  logic [tcw_pkg::COL_W-1:0]  row_end_val;
  logic [tcw_pkg::ATTR_W-1:0] color_r;

  logic                       op_r;
  logic [tcw_pkg::CHAR_W-1:0] ch_r;
  logic                       rd_ok_r;
  logic [tcw_pkg::ROW_W-1:0]  rd_phys_r;
  logic [tcw_pkg::CIDX_W-1:0] rd_col_r;

  logic [tcw_pkg::TCNT_W-1:0] tab_cnt_r, tab_cnt_nxt;
  logic [tcw_pkg::CIDX_W-1:0] sweep_r, sweep_nxt;
  logic [tcw_pkg::ADDR_W-1:0] clr_r;

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::ROWS * tcw_pkg::COLUMNS];
  logic                       mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata, rdata_r;

  tcw_pkg::out_item_t out_r;

  // Read-request decode at load time.
  logic                       rd_ok;
  logic [tcw_pkg::ROW_W:0]    rd_sum;
  logic [tcw_pkg::ROW_W-1:0]  rd_phys;

  assign rd_ok  = (int'(in_data.read_row) < tcw_pkg::ROWS) &&
                  (int'(in_data.read_col) < tcw_pkg::COLUMNS);
  assign rd_sum = {1'b0, tcw_pkg::ROW_W'(in_data.read_row)} + {1'b0, base_r};
  assign rd_phys = (rd_sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) ?
                   tcw_pkg::ROW_W'(rd_sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) :
                   tcw_pkg::ROW_W'(rd_sum);

  // Item decode.
  logic is_print, full, bottom, lf_item, do_lf;
  logic [tcw_pkg::ROW_W-1:0] phys_inc, phys_dec, base_inc;

  assign is_print = (ch_r != tcw_pkg::CH_NUL) && (ch_r != tcw_pkg::CH_BS) &&
                    (ch_r != tcw_pkg::CH_TAB) && (ch_r != tcw_pkg::CH_LF) &&
                    (ch_r != tcw_pkg::CH_CR);
  assign full     = (col_r >= COL_FULL);
  assign bottom   = (row_r == ROW_LAST);
  assign lf_item  = (ch_r == tcw_pkg::CH_LF);
  assign do_lf    = (op_r == tcw_pkg::OP_PUT) &&
                    (lf_item || (full && (is_print || (ch_r == tcw_pkg::CH_TAB))));
  assign phys_inc = (phys_r == ROW_LAST) ? '0 : phys_r + 1'b1;
  assign phys_dec = (phys_r == '0) ? ROW_LAST : phys_r - 1'b1;
  assign base_inc = (base_r == ROW_LAST) ? '0 : base_r + 1'b1;

  // Backspace target.
  logic [tcw_pkg::ROW_W-1:0] bs_row, bs_phys;
  logic [tcw_pkg::COL_W-1:0] bs_col_raw, bs_col;

  always_comb begin
    if (col_r != '0) begin
      bs_row     = row_r;
      bs_phys    = phys_r;
      bs_col_raw = col_r - 1'b1;
    end else if (row_r != '0) begin
      bs_row     = row_r - 1'b1;
      bs_phys    = phys_dec;
      bs_col_raw = row_end_r[phys_dec];
    end else begin
      bs_row     = row_r;
      bs_phys    = phys_r;
      bs_col_raw = col_r;
    end
    bs_col = (bs_col_raw >= COL_FULL) ? COL_LAST : bs_col_raw;
  end

  always_comb begin
    status             = '0;
    status.clr_last    = (clr_r == tcw_pkg::ADDR_W'(tcw_pkg::ROWS * tcw_pkg::COLUMNS - 1));
    status.need_scroll = do_lf && bottom;
    status.need_wrap   = do_lf && !bottom && !lf_item;
    status.need_tab    = (op_r == tcw_pkg::OP_PUT) && (ch_r == tcw_pkg::CH_TAB) && !full;
    status.sweep_last  = (sweep_r == tcw_pkg::CIDX_W'(tcw_pkg::COLUMNS - 1));
    status.tab_last    = (tab_cnt_r == tcw_pkg::TCNT_W'(1)) || (col_r == COL_LAST);
    status.item_lf     = lf_item;
  end

  always_comb begin
    row_nxt     = row_r;
    phys_nxt    = phys_r;
    base_nxt    = base_r;
    col_nxt     = col_r;
    tab_cnt_nxt = tab_cnt_r;
    sweep_nxt   = sweep_r;
    row_end_we  = 1'b0;
    row_end_idx = phys_r;
    row_end_val = '0;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr(phys_r, tcw_pkg::CIDX_W'(col_r));
    mem_wdata   = {color_r, tcw_pkg::BLANK_CHAR};
    mem_re      = 1'b0;
    mem_raddr   = cell_addr(rd_phys_r, rd_col_r);

    if (cmd.clr_we) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
    end

    if (cmd.exec && (op_r == tcw_pkg::OP_READ)) begin
      mem_re = 1'b1;
    end

    if (cmd.exec && (op_r == tcw_pkg::OP_PUT)) begin
      if (do_lf) begin
        col_nxt = '0;
        if (bottom) begin
          // Scroll: advance the ring base, the old top row becomes the new bottom.
          base_nxt    = base_inc;
          phys_nxt    = base_r;
          row_end_we  = 1'b1;
          row_end_idx = base_r;
          row_end_val = '0;
          sweep_nxt   = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          phys_nxt = phys_inc;
        end
      end else begin
        case (ch_r)
          tcw_pkg::CH_NUL: begin
          end
          tcw_pkg::CH_LF: begin
          end
          tcw_pkg::CH_CR: begin
            col_nxt = '0;
          end
          tcw_pkg::CH_BS: begin
            row_nxt     = bs_row;
            phys_nxt    = bs_phys;
            col_nxt     = bs_col;
            mem_we      = 1'b1;
            mem_waddr   = cell_addr(bs_phys, tcw_pkg::CIDX_W'(bs_col));
            row_end_we  = 1'b1;
            row_end_idx = bs_phys;
            row_end_val = (bs_col != '0) ? bs_col - 1'b1 : '0;
          end
          tcw_pkg::CH_TAB: begin
            tab_cnt_nxt = tcw_pkg::TCNT_W'(tcw_pkg::TAB_STEP) -
                          tcw_pkg::TCNT_W'(col_r % tcw_pkg::TAB_STEP);
          end
          default: begin
            mem_we      = 1'b1;
            mem_wdata   = {color_r, ch_r};
            row_end_we  = 1'b1;
            row_end_idx = phys_r;
            row_end_val = col_r + 1'b1;
            col_nxt     = col_r + 1'b1;
          end
        endcase
      end
    end

    if (cmd.sweep) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(phys_r, sweep_r);
      sweep_nxt = sweep_r + 1'b1;
    end

    if (cmd.tab) begin
      mem_we      = 1'b1;
      col_nxt     = col_r + 1'b1;
      tab_cnt_nxt = tab_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      phys_r    <= '0;
      base_r    <= '0;
      col_r     <= '0;
      color_r   <= tcw_pkg::RESET_ATTR;
      clr_r     <= '0;
      tab_cnt_r <= '0;
      sweep_r   <= '0;
      for (int i = 0; i < tcw_pkg::ROWS; i++) begin
        row_end_r[i] <= '0;
      end
    end else begin
      row_r     <= row_nxt;
      phys_r    <= phys_nxt;
      base_r    <= base_nxt;
      col_r     <= col_nxt;
      tab_cnt_r <= tab_cnt_nxt;
      sweep_r   <= sweep_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      if (cmd.clr_we) begin
        clr_r <= clr_r + 1'b1;
      end
      if (row_end_we) begin
        row_end_r[row_end_idx] <= row_end_val;
      end
    end
  end

  // Latch the item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_data.opcode;
      ch_r      <= in_data.char_code;
      rd_ok_r   <= rd_ok;
      rd_phys_r <= rd_phys;
      rd_col_r  <= tcw_pkg::CIDX_W'(in_data.read_col);
    end
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.cell_word  <= ((op_r == tcw_pkg::OP_READ) && rd_ok_r) ? rdata_r : '0;
      out_r.cursor_row <= tcw_pkg::CUR_ROW_W'(row_r);
      out_r.cursor_col <= tcw_pkg::CUR_COL_W'(col_r);
    end
  end

  assign out_data = out_r;

  `TCW_ASSERT_IMP(a_tab_in_row, clk, rst_n, cmd.tab, (col_r < COL_FULL) && (tab_cnt_r != '0), "tab write past row end")
  `TCW_ASSERT_IMP(a_phys_tracks_row, clk, rst_n, 1'b1, ((int'(row_r) + int'(base_r) >= tcw_pkg::ROWS) ? (int'(row_r) + int'(base_r) - tcw_pkg::ROWS) : (int'(row_r) + int'(base_r))) == int'(phys_r), "cursor physical row out of step with ring base")

endmodule

// File: src/text_console_writer_top.sv
// Top level of the text console writer: controller plus datapath.
//
// Text-mode console engine with an 80 x 25 store of 16-bit cells (attribute
// in the high byte, character in the low byte) and a cursor.
// Input channel (in_valid / in_stall / in_data): one transfer is one item,
// either a put of one character byte or a read of one screen cell.
// Result channel (out_valid / out_stall / out_data): exactly one transfer per
// item, with the cell read (0 for a put or out-of-range read) and the cursor after the item.
// Configuration: cfg_we with cfg_wdata loads the color attribute used for
// every cell that an item writes; write it only while the block is idle.
// Timing: an item is taken only while the controller is idle. Each item runs
// through the execute state, then the finish state, which loads the result
// register and raises out_valid; the next item is taken back in idle. A tab
// adds a padding step per cell (1 to 4); a wrap onto the next row adds a
// second execute step; a scroll adds a blanking sweep of the new bottom row,
// then one more execute step to resume a wrapped character or tab.
// Reset: the store is cleared to spaces with attribute 7 by a pass over all
// 2000 cells, one cell per cycle; in_stall stays high until it completes.
// Stall: a finished result waits in the output register; the next item is
// still taken, and its result waits until the pending one has moved.

module text_console_writer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tcw_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tcw_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

  tcw_pkg::ctrl_cmd_t  cmd;
  tcw_pkg::dp_status_t status;

  // Sequence the reset clear pass, then each item: execute, pad or sweep, then hand over.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold cursor, row ends, ring base and screen store; build the result.
  tcw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// File: test/tb.sv
// Testbench for the text console writer: screen predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 335;
  localparam int PHASES         = 6;

  // Shadow copy of the screen store and cursor; predicts every answer and
  // checks the answers that come back, in order.
  class screen_scoreboard;
    logic [tcw_pkg::CELL_W-1:0] cells [tcw_pkg::ROWS*tcw_pkg::COLUMNS];
    int                         row_end [tcw_pkg::ROWS];
    int                         cur_row;
    int                         cur_col;
    logic [tcw_pkg::ATTR_W-1:0] attr;
    tcw_pkg::out_item_t         awaited_answers [$];
    int errors, n_items, n_reads, n_scrolls, n_wraps, n_clamps;

    function new();
      for (int i = 0; i < tcw_pkg::ROWS*tcw_pkg::COLUMNS; i++)
        cells[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      for (int r = 0; r < tcw_pkg::ROWS; r++) row_end[r] = 0;
      cur_row = 0;
      cur_col = 0;
      attr = tcw_pkg::RESET_ATTR;
      errors = 0;
      n_items = 0;
      n_reads = 0;
      n_scrolls = 0;
      n_wraps = 0;
      n_clamps = 0;
    endfunction

    function logic [tcw_pkg::CELL_W-1:0] blank_cell();
      return {attr, tcw_pkg::BLANK_CHAR};
    endfunction

    function void write_cell(int r, int c, logic [tcw_pkg::CELL_W-1:0] v);
      if (r < tcw_pkg::ROWS && c < tcw_pkg::COLUMNS) cells[r*tcw_pkg::COLUMNS + c] = v;
    endfunction

    function void scroll_up();
      for (int r = 1; r < tcw_pkg::ROWS; r++) begin
        for (int c = 0; c < tcw_pkg::COLUMNS; c++)
          cells[(r-1)*tcw_pkg::COLUMNS + c] = cells[r*tcw_pkg::COLUMNS + c];
        row_end[r-1] = row_end[r];
      end
      for (int c = 0; c < tcw_pkg::COLUMNS; c++)
        cells[(tcw_pkg::ROWS-1)*tcw_pkg::COLUMNS + c] = blank_cell();
      row_end[tcw_pkg::ROWS-1] = 0;
      n_scrolls++;
    endfunction

    function void line_feed();
      if (cur_row + 1 < tcw_pkg::ROWS) cur_row++;
      else scroll_up();
      cur_col = 0;
    endfunction

    function void advance_screen(logic [tcw_pkg::CHAR_W-1:0] ch);
      int pad;
      case (ch)
        tcw_pkg::CH_NUL: ;
        tcw_pkg::CH_LF: line_feed();
        tcw_pkg::CH_CR: cur_col = 0;
        tcw_pkg::CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = row_end[cur_row];
          end
          if (cur_col >= tcw_pkg::COLUMNS) begin
            cur_col = tcw_pkg::COLUMNS - 1;
            n_clamps++;
          end
          write_cell(cur_row, cur_col, blank_cell());
          row_end[cur_row] = (cur_col > 0) ? cur_col - 1 : 0;
        end
        tcw_pkg::CH_TAB: begin
          if (cur_col >= tcw_pkg::COLUMNS) begin
            n_wraps++;
            line_feed();
          end
          pad = tcw_pkg::TAB_STEP - (cur_col % tcw_pkg::TAB_STEP);
          while (pad != 0 && cur_col < tcw_pkg::COLUMNS) begin
            write_cell(cur_row, cur_col, blank_cell());
            cur_col++;
            pad--;
          end
        end
        default: begin
          if (cur_col >= tcw_pkg::COLUMNS) begin
            n_wraps++;
            line_feed();
          end
          write_cell(cur_row, cur_col, {attr, ch});
          row_end[cur_row] = cur_col + 1;
          cur_col++;
        end
      endcase
    endfunction

    // Note one accepted input transfer and queue the answer it must produce.
    function void note_item(tcw_pkg::in_item_t it);
      tcw_pkg::out_item_t e;
      e = '0;
      n_items++;
      if (it.opcode == tcw_pkg::OP_PUT) begin
        advance_screen(it.char_code);
      end else begin
        n_reads++;
        if (it.read_row < tcw_pkg::ROWS && it.read_col < tcw_pkg::COLUMNS)
          e.cell_word = cells[it.read_row*tcw_pkg::COLUMNS + it.read_col];
      end
      e.cursor_row = cur_row[tcw_pkg::CUR_ROW_W-1:0];
      e.cursor_col = cur_col[tcw_pkg::CUR_COL_W-1:0];
      awaited_answers.push_back(e);
    endfunction

    // Compare one accepted result transfer with the oldest queued answer.
    function void check_result(tcw_pkg::out_item_t got);
      tcw_pkg::out_item_t e;
      if (awaited_answers.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      e = awaited_answers.pop_front();
      if (got.cell_word !== e.cell_word) begin
        $display("%0t: cell_word expected %h actual %h", $time, e.cell_word, got.cell_word);
        errors++;
      end
      if (got.cursor_row !== e.cursor_row) begin
        $display("%0t: cursor_row expected %0d actual %0d", $time, e.cursor_row,
                 got.cursor_row);
        errors++;
      end
      if (got.cursor_col !== e.cursor_col) begin
        $display("%0t: cursor_col expected %0d actual %0d", $time, e.cursor_col,
                 got.cursor_col);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  tcw_pkg::in_item_t          in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  tcw_pkg::out_item_t         out_data;
  logic                       cfg_we = 1'b0;
  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata = '0;

  logic idle_on = 1'b0;
  logic stall_on = 1'b0;
  int   phase_items;
  int   quiet_cycles = 0;
  screen_scoreboard sb;

  text_console_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Receiver: stall at random while enabled, with a probability of 17 percent.
  always @(posedge clk) begin
    out_stall <= stall_on && ($urandom_range(99) < 17);
  end

  // Check each result transfer; values sampled here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  // Watchdog: end the run when nothing transfers on either channel for too long.
  // The reset clearing pass fits well inside the limit.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d answers outstanding", $time,
               sb.awaited_answers.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [tcw_pkg::CHAR_W-1:0] rand_glyph();
    logic [tcw_pkg::CHAR_W-1:0] c;
    c = tcw_pkg::CHAR_W'($urandom_range(255, 1));
    while (c == tcw_pkg::CH_BS || c == tcw_pkg::CH_TAB || c == tcw_pkg::CH_LF ||
           c == tcw_pkg::CH_CR)
      c = tcw_pkg::CHAR_W'($urandom_range(255, 1));
    return c;
  endfunction

  function automatic tcw_pkg::in_item_t put_item(logic [tcw_pkg::CHAR_W-1:0] ch);
    tcw_pkg::in_item_t it;
    it.opcode = tcw_pkg::OP_PUT;
    it.char_code = ch;
    it.read_row = tcw_pkg::READ_ROW_W'($urandom);
    it.read_col = tcw_pkg::READ_COL_W'($urandom);
    return it;
  endfunction

  function automatic tcw_pkg::in_item_t read_item(logic [tcw_pkg::READ_ROW_W-1:0] r,
                                                  logic [tcw_pkg::READ_COL_W-1:0] c);
    tcw_pkg::in_item_t it;
    it.opcode = tcw_pkg::OP_READ;
    it.char_code = tcw_pkg::CHAR_W'($urandom);
    it.read_row = r;
    it.read_col = c;
    return it;
  endfunction

  // Drive one item; hold it until the transfer, then note it for prediction.
  // Called right after a rising edge; returns right after the transfer edge.
  task automatic send(input tcw_pkg::in_item_t it);
    if (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(it);
    if (!(it.opcode == tcw_pkg::OP_PUT && it.char_code == tcw_pkg::CH_NUL)) phase_items++;
  endtask

  // Drop valid and wait until every queued answer has come, then let the
  // block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(input logic [tcw_pkg::ATTR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.attr = v;
  endtask

  function automatic logic [tcw_pkg::CHAR_W-1:0] rand_control();
    case ($urandom_range(4))
      0: return tcw_pkg::CH_LF;
      1: return tcw_pkg::CH_CR;
      2: return tcw_pkg::CH_BS;
      3: return tcw_pkg::CH_TAB;
      default: return tcw_pkg::CH_NUL;
    endcase
  endfunction

  // One random burst of well-formed text, control sequences, reads or noise.
  task automatic run_scenario();
    int n;
    logic [31:0] raw;
    tcw_pkg::in_item_t it;
    case ($urandom_range(9))
      0, 1: begin
        // mixed text with scattered control codes
        n = $urandom_range(20, 1);
        for (int i = 0; i < n; i++)
          send(put_item(($urandom_range(99) < 70) ? rand_glyph() : rand_control()));
      end
      2: begin
        // fill the row to the end, then push past it or back up into it
        n = tcw_pkg::COLUMNS - sb.cur_col;
        for (int i = 0; i < n; i++) send(put_item(rand_glyph()));
        case ($urandom_range(3))
          0: send(put_item(rand_glyph()));
          1: send(put_item(tcw_pkg::CH_TAB));
          2: begin
            // back up into a full row: column lands on COLUMNS and is clamped
            send(put_item(tcw_pkg::CH_LF));
            send(put_item(tcw_pkg::CH_BS));
          end
          default: send(put_item(tcw_pkg::CH_BS));
        endcase
      end
      3: begin
        // run of newlines with an odd glyph, at times long enough to scroll from anywhere
        n = $urandom_range(30, 1);
        for (int i = 0; i < n; i++)
          send(put_item(($urandom_range(9) == 0) ? rand_glyph() : tcw_pkg::CH_LF));
      end
      4: begin
        n = $urandom_range(25, 1);
        for (int i = 0; i < n; i++)
          send(put_item(($urandom_range(1) == 0) ? tcw_pkg::CH_TAB : rand_glyph()));
      end
      5: begin
        n = $urandom_range(20, 1);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(9))
            0: send(put_item(tcw_pkg::CH_CR));
            1: send(put_item(tcw_pkg::CH_LF));
            default: send(put_item(tcw_pkg::CH_BS));
          endcase
        end
      end
      6, 7: begin
        // reads: mostly on the cursor row or in range, a few at random, often out of range
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(9))
            0, 1, 2, 3:
              send(read_item(tcw_pkg::READ_ROW_W'(sb.cur_row),
                             tcw_pkg::READ_COL_W'($urandom_range(tcw_pkg::COLUMNS - 1))));
            4, 5, 6, 7:
              send(read_item(tcw_pkg::READ_ROW_W'($urandom_range(tcw_pkg::ROWS - 1)),
                             tcw_pkg::READ_COL_W'($urandom_range(tcw_pkg::COLUMNS - 1))));
            default:
              send(read_item(tcw_pkg::READ_ROW_W'($urandom),
                             tcw_pkg::READ_COL_W'($urandom)));
          endcase
        end
      end
      8: begin
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          raw = $urandom;
          it = raw[$bits(tcw_pkg::in_item_t)-1:0];
          send(it);
        end
      end
      default: begin
        // short line, newline, then backspace back across the row boundary
        n = $urandom_range(10);
        for (int i = 0; i < n; i++) send(put_item(rand_glyph()));
        send(put_item(tcw_pkg::CH_LF));
        n = $urandom_range(15, 1);
        for (int i = 0; i < n; i++) send(put_item(tcw_pkg::CH_BS));
      end
    endcase
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      // Between phases the block is idle: switch the color attribute.
      case (p)
        0: ;
        1: write_attr(8'hFF);
        2: write_attr(8'h00);
        5: write_attr(tcw_pkg::RESET_ATTR);
        default: write_attr(tcw_pkg::ATTR_W'($urandom));
      endcase
      // phase 3 runs with no idling on either side
      idle_on = (p != 3);
      stall_on = (p != 3);
      phase_items = 0;

      if (p == 0) begin
        // reads of the cleared store at the corners and beyond the edges
        send(read_item('0, '0));
        send(read_item(5'd31, 7'd127));
        send(read_item(tcw_pkg::READ_ROW_W'(tcw_pkg::ROWS - 1),
                       tcw_pkg::READ_COL_W'(tcw_pkg::COLUMNS - 1)));
        send(read_item(tcw_pkg::READ_ROW_W'(tcw_pkg::ROWS),
                       tcw_pkg::READ_COL_W'(tcw_pkg::COLUMNS)));
        send(put_item(tcw_pkg::CH_NUL));
        send(put_item(8'hFF));
        send(put_item(8'h01));
        send(put_item(tcw_pkg::CH_TAB));
        send(put_item(tcw_pkg::CH_BS));
        send(put_item(tcw_pkg::CH_CR));
        send(put_item(8'h41));
        send(put_item(tcw_pkg::CH_LF));
        // backspace at column 0 steps up to the row above
        send(put_item(tcw_pkg::CH_BS));
        send(put_item(tcw_pkg::CH_CR));
        // backspace at the top left corner stays put
        send(put_item(tcw_pkg::CH_BS));
        send(put_item(8'h80));
        send(put_item(tcw_pkg::CH_LF));
        send(put_item(tcw_pkg::CH_TAB));
        send(put_item(tcw_pkg::CH_TAB));
        send(read_item('0, '0));
        send(read_item('0, 7'd1));
        send(read_item(5'd1, 7'd4));
      end

      while (phase_items < PHASE_ITEMS) run_scenario();
      drain();
    end

    $display("Covered %0d items (%0d reads) across %0d color settings, with and without idling.",
             sb.n_items, sb.n_reads, PHASES);
    $display("Saw %0d scrolls, %0d row wraps and %0d clamped backspaces.",
             sb.n_scrolls, sb.n_wraps, sb.n_clamps);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
